### design/lbps_pkg.sv
// Shared types, codes and constants for the LED blink pattern sequencer.
package lbps_pkg;

    localparam int PAT_REG_W  = 32;
    localparam int INTERVAL_W = 16;
    localparam int REPEAT_W   = 8;
    localparam int DELAY_W    = 16;
    localparam int CNT_W      = 22;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int IDX_W      = 7;
    localparam int OUT_W      = 8;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;

    typedef logic [FUNC_W-1:0]   func_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [1:0]          reg_idx_t;

    localparam func_t FUNC_TICK   = 2'd0;
    localparam func_t FUNC_START  = 2'd1;
    localparam func_t FUNC_CANCEL = 2'd2;

    localparam status_t STATUS_OK             = 2'd0;
    localparam status_t STATUS_ACTIVE         = 2'd1;
    localparam status_t STATUS_ZERO_REPEAT    = 2'd2;
    localparam status_t STATUS_SHORT_INTERVAL = 2'd3;

    localparam reg_idx_t REG_PATTERN  = 2'd0;
    localparam reg_idx_t REG_INTERVAL = 2'd1;
    localparam reg_idx_t REG_REPEAT   = 2'd2;
    localparam reg_idx_t REG_LOOP     = 2'd3;

    localparam logic [PAT_REG_W-1:0]  RST_PATTERN  = '0;
    localparam logic [INTERVAL_W-1:0] RST_INTERVAL = 16'd2;
    localparam logic [REPEAT_W-1:0]   RST_REPEAT   = 8'd1;
    localparam logic                  RST_LOOP     = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [PAT_REG_W-1:0]  pattern_bits;
        logic [INTERVAL_W-1:0] bit_interval;
        logic [REPEAT_W-1:0]   repeat_count;
        logic                  loop_mode;
    } cfg_t;

    typedef struct packed {
        logic load_item;
        logic exec;
        logic step_begin;
        logic scan_step;
        logic step_end;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_step;
        logic bp_zero;
        logic scan_more;
        logic out_free;
    } ctrl_stat_t;

endpackage

### design/led_blink_pattern_sequencer.sv
// An item is accepted in IDLE, decoded in DECODE and its result registered in RESULT;
// a tick that plays a run also passes through SCAN, where the run scan checks one
// pattern bit per cycle. One item at a time: no new item is accepted until the last
// result is in the output register, and RESULT waits while that register is still full.
// A result waits in an output register so the next transaction can be accepted.
// Reset (rst_n, asynchronous, active low) stops the pattern, turns the LED off
// and loads the register defaults: pattern 0, interval 2, one repeat, no loop.
module led_blink_pattern_sequencer
    import lbps_pkg::*;
#(
    parameter int PATTERN_WIDTH = 32,
    parameter int MIN_INTERVAL  = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [DELAY_W-1:0]    s_tdata,   // [15:0] start_delay
    input  logic [FUNC_W-1:0]     s_tuser,   // [1:0] func
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,   // [0] led_on, [1] busy_res, [2] done_res,
                                             // [4:3] status, [7:5] zero
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;
    logic       active;

    lbps_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .active  (active),
        .cfg     (cfg)
    );

    lbps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lbps_dp #(
        .PATTERN_WIDTH (PATTERN_WIDTH),
        .MIN_INTERVAL  (MIN_INTERVAL)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .cfg      (cfg),
        .m_tready (m_tready),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .active   (active)
    );

endmodule

### design/lbps_cfg.sv
// Configuration register file with its APB-style access port.
module lbps_cfg
    import lbps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  active,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    // Registers are frozen while a pattern is running.
    assign wr_en   = psel && penable && pwrite && !active;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_PATTERN:  cfg_next.pattern_bits = pwdata[PAT_REG_W-1:0];
                REG_INTERVAL: cfg_next.bit_interval = pwdata[INTERVAL_W-1:0];
                REG_REPEAT:   cfg_next.repeat_count = pwdata[REPEAT_W-1:0];
                REG_LOOP:     cfg_next.loop_mode    = pwdata[0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_PATTERN:  prdata = CFG_DATA_W'(cfg_reg.pattern_bits);
            REG_INTERVAL: prdata = CFG_DATA_W'(cfg_reg.bit_interval);
            REG_REPEAT:   prdata = CFG_DATA_W'(cfg_reg.repeat_count);
            REG_LOOP:     prdata = CFG_DATA_W'(cfg_reg.loop_mode);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_bits <= RST_PATTERN;
            cfg_reg.bit_interval <= RST_INTERVAL;
            cfg_reg.repeat_count <= RST_REPEAT;
            cfg_reg.loop_mode    <= RST_LOOP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### design/lbps_ctrl.sv
// Controller state machine that sequences each command through the datapath.
module lbps_ctrl
    import lbps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  ctrl_stat_t stat,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                // A tick with an expired countdown plays the next run, or completes the pattern if no bits are left.
                if (stat.need_step)
                begin
                    cmd.step_begin = 1'b1;
                    state_next     = stat.bp_zero ? ST_RESULT : ST_SCAN;
                end
                else
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_RESULT;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_more)
                begin
                    cmd.scan_step = 1'b1;
                end
                else
                begin
                    cmd.step_end = 1'b1;
                    state_next   = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### design/lbps_dp.sv
// Datapath: sequencer state, bit-serial run scan and the result register.
module lbps_dp
    import lbps_pkg::*;
#(
    parameter int PATTERN_WIDTH = 32,
    parameter int MIN_INTERVAL  = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [DELAY_W-1:0] s_tdata,
    input  logic [FUNC_W-1:0]  s_tuser,
    input  ctrl_cmd_t          cmd,
    input  cfg_t               cfg,
    input  logic               m_tready,
    output ctrl_stat_t         stat,
    output logic               m_tvalid,
    output logic [OUT_W-1:0]   m_tdata,
    output logic               active
);

    localparam int POS_W = $clog2(PATTERN_WIDTH + 1);
    localparam int ACC_W = INTERVAL_W + POS_W;
    localparam logic [POS_W-1:0] POS_FULL = POS_W'(PATTERN_WIDTH);

    function automatic logic pat_bit(input logic [PAT_REG_W-1:0] pat,
                                     input logic [POS_W-1:0]     pos);
        logic [IDX_W-1:0] idx;
        idx = IDX_W'(pos);
        // Positions above the register read as zero.
        if (idx < IDX_W'(PAT_REG_W))
            return pat[idx[$clog2(PAT_REG_W)-1:0]];
        else
            return 1'b0;
    endfunction

    func_t                 func_reg;
    logic [DELAY_W-1:0]    delay_reg;
    logic [POS_W-1:0]      bitpos_reg, bitpos_next;
    logic [REPEAT_W-1:0]   passes_reg, passes_next;
    logic                  active_reg, active_next;
    logic                  led_reg, led_next;
    logic [CNT_W-1:0]      cd_reg, cd_next;
    logic [POS_W-1:0]      rem_reg, rem_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic                  run_on_reg, run_on_next;
    logic                  done_reg, done_next;
    status_t               status_reg, status_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]      out_data_reg, out_data_next;
    logic [POS_W-1:0]      bitpos_m1;
    logic [POS_W-1:0]      rem_m1;
    logic                  start_bit;

    assign bitpos_m1 = bitpos_reg - 1'b1;
    assign rem_m1    = rem_reg - 1'b1;
    assign start_bit = pat_bit(cfg.pattern_bits, bitpos_m1);

    assign stat.need_step = (func_reg == FUNC_TICK) && active_reg && (cd_reg == '0);
    assign stat.bp_zero   = (bitpos_reg == '0);
    assign stat.scan_more = (rem_reg != '0) && (pat_bit(cfg.pattern_bits, rem_m1) == run_on_reg);
    assign stat.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign active   = active_reg;

    always_comb
    begin
        bitpos_next    = bitpos_reg;
        passes_next    = passes_reg;
        active_next    = active_reg;
        led_next       = led_reg;
        cd_next        = cd_reg;
        rem_next       = rem_reg;
        acc_next       = acc_reg;
        run_on_next    = run_on_reg;
        done_next      = done_reg;
        status_next    = status_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;

        if (cmd.load_item)
        begin
            done_next   = 1'b0;
            status_next = STATUS_OK;
        end

        if (cmd.exec)
        begin
            case (func_reg)
                FUNC_TICK:
                begin
                    if (active_reg)
                        cd_next = cd_reg - 1'b1;
                end
                FUNC_START:
                begin
                    if (active_reg)
                        status_next = STATUS_ACTIVE;
                    else if (cfg.bit_interval < INTERVAL_W'(MIN_INTERVAL))
                        status_next = STATUS_SHORT_INTERVAL;
                    else if (!cfg.loop_mode && (cfg.repeat_count == '0))
                        status_next = STATUS_ZERO_REPEAT;
                    else
                    begin
                        passes_next = cfg.loop_mode ? '0 : cfg.repeat_count - 1'b1;
                        bitpos_next = POS_FULL;
                        active_next = 1'b1;
                        cd_next     = CNT_W'(delay_reg);
                    end
                end
                FUNC_CANCEL:
                begin
                    led_next    = 1'b0;
                    active_next = 1'b0;
                    passes_next = '0;
                    bitpos_next = '0;
                    cd_next     = '0;
                end
                default:
                begin
                    cd_next = cd_reg;
                end
            endcase
        end

        if (cmd.step_begin)
        begin
            if (bitpos_reg == '0)
            begin
                // The last pass ended on a lit run: complete now.
                led_next    = 1'b0;
                active_next = 1'b0;
                passes_next = '0;
                cd_next     = '0;
                done_next   = 1'b1;
            end
            else
            begin
                led_next    = start_bit;
                run_on_next = start_bit;
                rem_next    = bitpos_m1;
                acc_next    = ACC_W'(cfg.bit_interval);
            end
        end

        if (cmd.scan_step)
        begin
            rem_next = rem_m1;
            acc_next = acc_reg + ACC_W'(cfg.bit_interval);
        end

        if (cmd.step_end)
        begin
            cd_next = (acc_reg == '0) ? '0 : CNT_W'(acc_reg - 1'b1);
            if (rem_reg != '0)
                bitpos_next = rem_reg;
            else if (cfg.loop_mode)
                bitpos_next = POS_FULL;
            else if (passes_reg != '0)
            begin
                passes_next = passes_reg - 1'b1;
                bitpos_next = POS_FULL;
            end
            else
            begin
                bitpos_next = '0;
                passes_next = '0;
                // A final run that is dark ends the pattern at once.
                if (!run_on_reg)
                begin
                    led_next    = 1'b0;
                    active_next = 1'b0;
                    cd_next     = '0;
                    done_next   = 1'b1;
                end
            end
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {3'b000, status_reg, done_reg, active_reg, led_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bitpos_reg    <= '0;
            passes_reg    <= '0;
            active_reg    <= 1'b0;
            led_reg       <= 1'b0;
            cd_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bitpos_reg    <= bitpos_next;
            passes_reg    <= passes_next;
            active_reg    <= active_next;
            led_reg       <= led_next;
            cd_reg        <= cd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            func_reg  <= s_tuser;
            delay_reg <= s_tdata;
        end
        rem_reg      <= rem_next;
        acc_reg      <= acc_next;
        run_on_reg   <= run_on_next;
        done_reg     <= done_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

`ifndef SYNTH
    a_led_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
        led_reg |-> active_reg)
        else $error("LED lit while no pattern is active");

    a_idle_state_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> ((bitpos_reg == '0) && (cd_reg == '0)))
        else $error("position or countdown left over while idle");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        bitpos_reg <= POS_FULL)
        else $error("bit position beyond pattern width");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg[2]) |-> !out_data_reg[1])
        else $error("completion reported while still busy");

    a_done_no_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg[2]) |-> (out_data_reg[4:3] == STATUS_OK))
        else $error("completion reported together with a start error");
`endif

endmodule
